// ===== rtl/wsfu_pkg.sv =====
`default_nettype none
package wsfu_pkg;

    // stream byte in
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_frame;
    } in_word_t;

    // result word out
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       final_flag;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
        logic       empty_frame;
    } out_word_t;

    // classified word between front and back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key_byte;   // zero when unmasked
        logic       fin;
        logic [3:0] opcode;
        logic       last;
        logic       empty;
    } q_word_t;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

// ===== rtl/wsfu_front.sv =====
`default_nettype none
module wsfu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire wsfu_pkg::in_word_t in_word,
    output logic                   push,
    output wsfu_pkg::q_word_t      push_word
);

    wsfu_pkg::phase_t phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  hdr_left_reg, hdr_left_next;
    logic [63:0] len_reg, len_next;      // assembled length, then bytes remaining
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;

    logic [7:0]  b;
    logic [6:0]  code;
    logic        len_known;
    logic [63:0] len_val;
    logic        go_payload;
    logic [63:0] pay_len;
    logic [7:0]  kb;

    assign b    = in_word.data_byte;
    assign code = b[6:0];

    always_comb
    begin
        case (idx_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        hdr_left_next = hdr_left_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        len_known     = 1'b0;
        len_val       = '0;
        go_payload    = 1'b0;
        pay_len       = '0;
        push          = 1'b0;
        push_word     = '0;
        push_word.fin    = fin_reg;
        push_word.opcode = opcode_reg;

        if (accept)
        begin
            if (in_word.start_frame)
            begin
                fin_next    = b[7];
                opcode_next = b[3:0];
                phase_next  = wsfu_pkg::PH_SECOND;
            end
            else
            begin
                unique case (phase_reg)
                    wsfu_pkg::PH_SECOND:
                    begin
                        masked_next = b[7];
                        if (code == wsfu_pkg::LEN_CODE_16)
                        begin
                            len_next      = '0;
                            hdr_left_next = wsfu_pkg::EXT16_BYTES;
                            phase_next    = wsfu_pkg::PH_EXTLEN;
                        end
                        else if (code == wsfu_pkg::LEN_CODE_64)
                        begin
                            len_next      = '0;
                            hdr_left_next = wsfu_pkg::EXT64_BYTES;
                            phase_next    = wsfu_pkg::PH_EXTLEN;
                        end
                        else
                        begin
                            len_known = 1'b1;
                            len_val   = {57'd0, code};
                        end
                    end
                    wsfu_pkg::PH_EXTLEN:
                    begin
                        len_next      = {len_reg[55:0], b};
                        hdr_left_next = hdr_left_reg - 4'd1;
                        if (hdr_left_reg == 4'd1)
                        begin
                            len_known = 1'b1;
                            len_val   = {len_reg[55:0], b};
                        end
                    end
                    wsfu_pkg::PH_KEY:
                    begin
                        key_next      = {key_reg[23:0], b};
                        hdr_left_next = hdr_left_reg - 4'd1;
                        if (hdr_left_reg == 4'd1)
                        begin
                            go_payload = 1'b1;
                            pay_len    = len_reg;
                        end
                    end
                    wsfu_pkg::PH_PAYLOAD:
                    begin
                        push               = 1'b1;
                        push_word.data     = b;
                        push_word.key_byte = masked_reg ? kb : 8'd0;
                        push_word.last     = (len_reg == 64'd1);
                        len_next           = len_reg - 64'd1;
                        idx_next           = idx_reg + 2'd1;
                        if (len_reg == 64'd1)
                        begin
                            phase_next = wsfu_pkg::PH_FIRST;
                        end
                    end
                    default:
                    begin
                        // first header byte; unused codes land here too
                        fin_next    = b[7];
                        opcode_next = b[3:0];
                        phase_next  = wsfu_pkg::PH_SECOND;
                    end
                endcase
            end

            if (len_known)
            begin
                if (masked_next)
                begin
                    len_next      = len_val;
                    key_next      = '0;
                    hdr_left_next = wsfu_pkg::KEY_BYTES;
                    phase_next    = wsfu_pkg::PH_KEY;
                end
                else
                begin
                    go_payload = 1'b1;
                    pay_len    = len_val;
                end
            end

            if (go_payload)
            begin
                idx_next = 2'd0;
                len_next = pay_len;
                if (pay_len == 64'd0)
                begin
                    phase_next      = wsfu_pkg::PH_FIRST;
                    push            = 1'b1;
                    push_word.last  = 1'b1;
                    push_word.empty = 1'b1;
                end
                else
                begin
                    phase_next = wsfu_pkg::PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wsfu_pkg::PH_FIRST;
            fin_reg      <= 1'b0;
            opcode_reg   <= 4'd0;
            masked_reg   <= 1'b0;
            hdr_left_reg <= 4'd0;
            len_reg      <= 64'd0;
            key_reg      <= 32'd0;
            idx_reg      <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            hdr_left_reg <= hdr_left_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            idx_reg      <= idx_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsfu_queue.sv =====
`default_nettype none
module wsfu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wsfu_pkg::q_word_t push_word,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output wsfu_pkg::q_word_t      head_word
);

    wsfu_pkg::q_word_t mem [wsfu_pkg::QUEUE_DEPTH];

    logic [wsfu_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wsfu_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wsfu_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full       = (count_reg == wsfu_pkg::QCNT_W'(wsfu_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == wsfu_pkg::QPTR_W'(wsfu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + wsfu_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == wsfu_pkg::QPTR_W'(wsfu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + wsfu_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + wsfu_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - wsfu_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsfu_back.sv =====
`default_nettype none
module wsfu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire wsfu_pkg::q_word_t head_word,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wsfu_pkg::out_word_t    out_word
);

    logic                valid_reg, valid_next;
    wsfu_pkg::out_word_t word_reg, word_next;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (pop)
        begin
            valid_next              = 1'b1;
            word_next.payload_byte  = head_word.data ^ head_word.key_byte;
            word_next.final_flag    = head_word.fin;
            word_next.frame_opcode  = head_word.opcode;
            word_next.last_of_frame = head_word.last;
            word_next.empty_frame   = head_word.empty;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_unmasker.sv =====
`default_nettype none
// Channel   Dir  Handshake            Word
// in        in   in_valid/in_ready    in_word  (data_byte, start_frame)
// out       out  out_valid/out_ready  out_word (payload_byte, final_flag,
//                                     frame_opcode, last_of_frame, empty_frame)
//
// One byte per cycle while the queue is not full; a payload word reaches
// out via the queue and the output reg (parser writes queue, head loads reg).
// Header bytes give no word; a zero-length frame gives one empty word.
// Reset puts the parser at the first header byte and empties the queue.
// in_ready drops only while the queue is full, i.e. once out has stalled
// with three words held (two in the queue, one in the output register).
module websocket_frame_unmasker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wsfu_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wsfu_pkg::out_word_t    out_word
);

    logic              accept;
    logic              push;
    wsfu_pkg::q_word_t push_word;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    wsfu_pkg::q_word_t head_word;

    // The parser never pushes more than one word per byte, so a free
    // queue slot is all it needs to take the next byte.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Front: header parse, length/key capture, payload classification.
    wsfu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_word   (in_word),
        .push      (push),
        .push_word (push_word)
    );

    // Short queue decouples parser from the output stall.
    wsfu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // Back: key XOR and registered output.
    wsfu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule
`default_nettype wire
